@@ hdl/dlcrf_pkg.sv @@
// Package of the dust low complexity read filter: field widths, register
// indexes, class codes, the base coding function and the shared types.
// No dependencies.
package dlcrf_pkg;

  localparam int CODE_BITS       = 3;
  localparam int MAX_K_DEF       = 4;
  localparam int MAX_READ_LEN_DEF = 1024;

  localparam int CHAR_W      = 8;
  localparam int COUNT_W     = 11;
  localparam int EPOCH_W     = 16;
  localparam int SCORE_W     = 20;
  localparam int SCORE_OUT_W = 19;
  localparam int LEN_W       = 11;
  localparam int CLASS_W     = 2;
  localparam int MINLEN_W    = 11;
  localparam int KSZ_W       = 3;
  localparam int CUTOFF_W    = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KMER_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUST_CUTOFF = 2'd2;

  localparam logic [KSZ_W-1:0] KSZ_RESET = 3'd4;

  localparam logic [CLASS_W-1:0] CLASS_PASS  = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_SHORT = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_DUST  = 2'd2;

  localparam logic [CODE_BITS-1:0] CODE_OTHER = 3'd0;
  localparam logic [CODE_BITS-1:0] CODE_N     = 3'd1;
  localparam logic [CODE_BITS-1:0] CODE_A     = 3'd2;
  localparam logic [CODE_BITS-1:0] CODE_C     = 3'd3;
  localparam logic [CODE_BITS-1:0] CODE_G     = 3'd4;
  localparam logic [CODE_BITS-1:0] CODE_T     = 3'd5;

  localparam logic [CHAR_W-1:0] FOLD_LIMIT  = 8'd96;
  localparam logic [CHAR_W-1:0] FOLD_OFFSET = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_N = 8'h4E;
  localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
  localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
  localparam logic [SCORE_OUT_W-1:0] SCORE_OUT_MAX = '1;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [COUNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic [CLASS_W-1:0]     read_class;
    logic [LEN_W-1:0]       read_length;
    logic [SCORE_OUT_W-1:0] repeat_score;
    logic                   length_overflow;
  } result_t;

  function automatic logic [CODE_BITS-1:0] base_code(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] u;
    logic [CODE_BITS-1:0] code;
    u = (c > FOLD_LIMIT) ? c - FOLD_OFFSET : c;
    case (u)
      CHAR_N:  code = CODE_N;
      CHAR_A:  code = CODE_A;
      CHAR_C:  code = CODE_C;
      CHAR_G:  code = CODE_G;
      CHAR_T:  code = CODE_T;
      default: code = CODE_OTHER;
    endcase
    return code;
  endfunction

endpackage

@@ hdl/dlcrf_base_if.sv @@
// Input channel of the dust read filter: one base character per item.
// Depends on dlcrf_pkg.
interface dlcrf_base_if;
  logic                       valid;
  logic                       ready;
  logic [dlcrf_pkg::CHAR_W-1:0] base_char;
  logic                       last_base;

  modport source (output valid, base_char, last_base, input ready);
  modport sink (input valid, base_char, last_base, output ready);
endinterface

@@ hdl/dlcrf_result_if.sv @@
// Output channel of the dust read filter: one classification item per read.
// Depends on dlcrf_pkg.
interface dlcrf_result_if;
  logic                              valid;
  logic                              ready;
  logic [dlcrf_pkg::CLASS_W-1:0]     read_class;
  logic [dlcrf_pkg::LEN_W-1:0]       read_length;
  logic [dlcrf_pkg::SCORE_OUT_W-1:0] repeat_score;
  logic                              length_overflow;

  modport source (output valid, read_class, read_length, repeat_score, length_overflow,
                  input ready);
  modport sink (input valid, read_class, read_length, repeat_score, length_overflow,
                output ready);
endinterface

@@ hdl/dust_low_complexity_read_filter_unit.sv @@
// Top level of the dust low complexity read filter: base coding, rolling
// k-mer, scoring pipeline and read classification.
// Depends on dlcrf_pkg, dlcrf_base_if, dlcrf_result_if, dlcrf_kmer_table, dlcrf_result_queue.
//
//   channel   direction  item                        handshake
//   in_if     in         one base character of a read  valid/ready
//   out_if    out        one class per read            valid/ready
//   cfg       in         register write                cfg_we_i only
//
// One base is taken every cycle while in_if.ready is high; the count table does one
// read-modify-write per k-mer-ending base, with the result of the previous write forwarded.
// After its last base, the class item of a read passes s1_last_q, s2_valid_q and the queue.
// After reset, and again each time the read number wraps after 65535 reads,
// the table is swept over its 2**(3*MAX_K) entries (4096 by default) with in_if.ready low.
// After a wrap, the sweep holds off while the table write of the last base is done.
// A four-entry result queue absorbs output stalls; ready drops when it and
// the results still in the pipeline would fill it.
module dust_low_complexity_read_filter_unit #(
  parameter int MAX_K        = dlcrf_pkg::MAX_K_DEF,
  parameter int MAX_READ_LEN = dlcrf_pkg::MAX_READ_LEN_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  dlcrf_base_if.sink                       in_if,
  dlcrf_result_if.source                   out_if,
  input  logic                             cfg_we_i,
  input  logic [dlcrf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dlcrf_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW     = dlcrf_pkg::CODE_BITS * MAX_K;
  localparam int POS_W  = $clog2(MAX_READ_LEN + 1);
  localparam int PROD_W = dlcrf_pkg::CUTOFF_W + POS_W;
  localparam int CMP_W  = (POS_W > dlcrf_pkg::MINLEN_W) ? POS_W : dlcrf_pkg::MINLEN_W;
  localparam int CNT_W  = $clog2(dlcrf_pkg::QUEUE_DEPTH + 1);
  localparam int KSZ_W  = dlcrf_pkg::KSZ_W;

  logic [dlcrf_pkg::MINLEN_W-1:0] min_len_q;
  logic [KSZ_W-1:0]               ksz_q;
  logic [dlcrf_pkg::CUTOFF_W-1:0] cutoff_q;

  logic [AW-1:0]                  roll_q;
  logic [POS_W-1:0]               pos_q;
  logic                           ovf_q;
  logic [dlcrf_pkg::EPOCH_W-1:0]  epoch_q;

  logic                           s1_last_q;
  logic [POS_W-1:0]               s1_len_q;
  logic                           s1_ovf_q;
  logic [POS_W-1:0]               s1_positions_q;
  logic [dlcrf_pkg::SCORE_W-1:0]  score_q;

  logic                           s2_valid_q;
  logic [dlcrf_pkg::SCORE_W-1:0]  s2_score_q;
  logic [POS_W-1:0]               s2_len_q;
  logic                           s2_ovf_q;
  logic [PROD_W-1:0]              s2_prod_q;

  logic                           accept;
  logic [KSZ_W-1:0]               k_eff;
  logic [POS_W-1:0]               k_pos;
  logic                           in_range;
  logic [AW-1:0]                  roll_d;
  logic [AW-1:0]                  idx_mask;
  logic                           hit;
  logic [POS_W-1:0]               pos_d;
  logic                           ovf_d;
  logic [POS_W-1:0]               positions;
  logic [dlcrf_pkg::EPOCH_W-1:0]  epoch_inc;
  logic                           epoch_wrap;

  logic                           tbl_busy;
  logic [dlcrf_pkg::COUNT_W-1:0]  prior;
  logic [dlcrf_pkg::SCORE_W:0]    score_sum;
  logic [dlcrf_pkg::SCORE_W-1:0]  score_sat;

  logic [CNT_W-1:0]               q_count;
  logic [CNT_W:0]                 q_pending;
  dlcrf_pkg::result_t             res_d;
  dlcrf_pkg::result_t             res_out;
  logic                           q_valid;

  // Stage 0: code the base, roll the k-mer and issue the table read.
  always_comb begin
    if (ksz_q == '0) begin
      k_eff = KSZ_W'(1);
    end else if (ksz_q > KSZ_W'(MAX_K)) begin
      k_eff = KSZ_W'(MAX_K);
    end else begin
      k_eff = ksz_q;
    end
    k_pos = POS_W'(k_eff);
    for (int b = 0; b < AW; b++) begin
      idx_mask[b] = (b < dlcrf_pkg::CODE_BITS * int'(k_eff));
    end
    in_range = (pos_q < POS_W'(MAX_READ_LEN));
    roll_d = AW'({roll_q, dlcrf_pkg::base_code(in_if.base_char)});
    hit = accept && in_range && (pos_q >= k_pos - 1'b1);
    pos_d = in_range ? pos_q + 1'b1 : pos_q;
    ovf_d = ovf_q || !in_range;
    positions = (pos_d >= k_pos) ? pos_d - k_pos + 1'b1 : '0;
    epoch_inc = epoch_q + 1'b1;
    epoch_wrap = (epoch_inc == '0);
  end

  assign q_pending = (CNT_W + 1)'(q_count) + (CNT_W + 1)'(s1_last_q)
                   + (CNT_W + 1)'(s2_valid_q);
  assign in_if.ready = !tbl_busy && (q_pending < (CNT_W + 1)'(dlcrf_pkg::QUEUE_DEPTH));
  assign accept = in_if.valid && in_if.ready;

  dlcrf_kmer_table #(
    .AW (AW)
  ) u_table (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_hit_i     (hit),
    .req_idx_i     (roll_d & idx_mask),
    .req_epoch_i   (epoch_q),
    .clear_start_i (accept && in_if.last_base && epoch_wrap),
    .busy_o        (tbl_busy),
    .prior_o       (prior)
  );

  // Stage 1: accumulate the prior count of the k-mer into the score.
  always_comb begin
    score_sum = (dlcrf_pkg::SCORE_W + 1)'(score_q) + (dlcrf_pkg::SCORE_W + 1)'(prior);
    score_sat = score_sum[dlcrf_pkg::SCORE_W] ? dlcrf_pkg::SCORE_MAX
                                              : score_sum[dlcrf_pkg::SCORE_W-1:0];
  end

  // Stage 2: classify the read.
  always_comb begin
    if ((min_len_q != '0) && !s2_ovf_q && (CMP_W'(s2_len_q) < CMP_W'(min_len_q))) begin
      res_d.read_class = dlcrf_pkg::CLASS_SHORT;
    end else if ((cutoff_q != '0) && (PROD_W'(s2_score_q) > s2_prod_q)) begin
      res_d.read_class = dlcrf_pkg::CLASS_DUST;
    end else begin
      res_d.read_class = dlcrf_pkg::CLASS_PASS;
    end
    res_d.read_length = dlcrf_pkg::LEN_W'(s2_len_q);
    res_d.repeat_score = (s2_score_q > dlcrf_pkg::SCORE_W'(dlcrf_pkg::SCORE_OUT_MAX))
                       ? dlcrf_pkg::SCORE_OUT_MAX
                       : s2_score_q[dlcrf_pkg::SCORE_OUT_W-1:0];
    res_d.length_overflow = s2_ovf_q;
  end

  dlcrf_result_queue #(
    .DEPTH (dlcrf_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s2_valid_q),
    .push_data_i (res_d),
    .pop_ready_i (out_if.ready),
    .valid_o     (q_valid),
    .data_o      (res_out),
    .count_o     (q_count)
  );

  assign out_if.valid           = q_valid;
  assign out_if.read_class      = res_out.read_class;
  assign out_if.read_length     = res_out.read_length;
  assign out_if.repeat_score    = res_out.repeat_score;
  assign out_if.length_overflow = res_out.length_overflow;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_len_q       <= pos_d;
      s1_ovf_q       <= ovf_d;
      s1_positions_q <= positions;
    end
    if (s1_last_q) begin
      s2_score_q <= score_sat;
      s2_len_q   <= s1_len_q;
      s2_ovf_q   <= s1_ovf_q;
      s2_prod_q  <= PROD_W'(cutoff_q) * PROD_W'(s1_positions_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q  <= '0;
      ksz_q      <= dlcrf_pkg::KSZ_RESET;
      cutoff_q   <= '0;
      roll_q     <= '0;
      pos_q      <= '0;
      ovf_q      <= 1'b0;
      epoch_q    <= dlcrf_pkg::EPOCH_W'(1);
      s1_last_q  <= 1'b0;
      score_q    <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          dlcrf_pkg::CFG_MIN_LENGTH:  min_len_q <= cfg_data_i[dlcrf_pkg::MINLEN_W-1:0];
          dlcrf_pkg::CFG_KMER_SIZE:   ksz_q <= cfg_data_i[KSZ_W-1:0];
          dlcrf_pkg::CFG_DUST_CUTOFF: cutoff_q <= cfg_data_i[dlcrf_pkg::CUTOFF_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (in_if.last_base) begin
          roll_q  <= '0;
          pos_q   <= '0;
          ovf_q   <= 1'b0;
          epoch_q <= epoch_wrap ? dlcrf_pkg::EPOCH_W'(1) : epoch_inc;
        end else begin
          if (in_range) begin
            roll_q <= roll_d;
          end
          pos_q <= pos_d;
          ovf_q <= ovf_d;
        end
      end
      s1_last_q  <= accept && in_if.last_base;
      score_q    <= s1_last_q ? '0 : score_sat;
      s2_valid_q <= s1_last_q;
    end
  end

endmodule

@@ hdl/dlcrf_kmer_table.sv @@
// K-mer count table: one synchronous memory of epoch-tagged counts with a
// read-modify-write path, write forwarding and a clearing sweep.
// Depends on dlcrf_pkg.
module dlcrf_kmer_table #(
  parameter int AW = dlcrf_pkg::CODE_BITS * dlcrf_pkg::MAX_K_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_hit_i,
  input  logic [AW-1:0]                 req_idx_i,
  input  logic [dlcrf_pkg::EPOCH_W-1:0] req_epoch_i,
  input  logic                          clear_start_i,
  output logic                          busy_o,
  output logic [dlcrf_pkg::COUNT_W-1:0] prior_o
);

  localparam int DEPTH = 2 ** AW;

  dlcrf_pkg::entry_t mem [DEPTH];
  dlcrf_pkg::entry_t rdata_q;
  dlcrf_pkg::entry_t wr_entry_q;
  dlcrf_pkg::entry_t cur_entry;
  dlcrf_pkg::entry_t mem_wdata;

  logic                          hit_q;
  logic [AW-1:0]                 idx_q;
  logic [dlcrf_pkg::EPOCH_W-1:0] epoch_q;
  logic                          wr_valid_q;
  logic [AW-1:0]                 wr_idx_q;
  logic                          busy_q;
  logic [AW-1:0]                 clr_addr_q;

  logic                          clr_step;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [dlcrf_pkg::COUNT_W-1:0] prior;
  logic [dlcrf_pkg::COUNT_W-1:0] next_count;

  always_comb begin
    cur_entry = (wr_valid_q && (wr_idx_q == idx_q)) ? wr_entry_q : rdata_q;
    prior = (cur_entry.epoch == epoch_q) ? cur_entry.count : '0;
    next_count = (prior < dlcrf_pkg::COUNT_MAX) ? prior + 1'b1 : prior;
    clr_step = busy_q && !hit_q;
    mem_we = hit_q || clr_step;
    if (hit_q) begin
      mem_waddr = idx_q;
      mem_wdata = '{epoch: epoch_q, count: next_count};
    end else begin
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end
  end

  assign prior_o = hit_q ? prior : '0;
  assign busy_o  = busy_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (req_hit_i) begin
      rdata_q <= mem[req_idx_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_hit_i) begin
      idx_q   <= req_idx_i;
      epoch_q <= req_epoch_i;
    end
    if (hit_q) begin
      wr_idx_q   <= idx_q;
      wr_entry_q <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q      <= 1'b0;
      wr_valid_q <= 1'b0;
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      hit_q <= req_hit_i;
      if (hit_q) begin
        wr_valid_q <= 1'b1;
      end else if (clr_step) begin
        wr_valid_q <= 1'b0;
      end
      if (clear_start_i) begin
        busy_q     <= 1'b1;
        clr_addr_q <= '0;
      end else if (clr_step) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == AW'(DEPTH - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule

@@ hdl/dlcrf_result_queue.sv @@
// Small queue of finished result items between the scoring pipeline and
// the output channel. Depends on dlcrf_pkg.
module dlcrf_result_queue #(
  parameter int DEPTH = dlcrf_pkg::QUEUE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  dlcrf_pkg::result_t           push_data_i,
  input  logic                         pop_ready_i,
  output logic                         valid_o,
  output dlcrf_pkg::result_t           data_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dlcrf_pkg::result_t store_q [DEPTH];
  logic [PTR_W-1:0] head_q;
  logic [PTR_W-1:0] tail_q;
  logic [CNT_W-1:0] count_q;
  logic             pop;

  assign valid_o = (count_q != '0);
  assign data_o  = store_q[head_q];
  assign count_o = count_q;
  assign pop     = valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[tail_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        tail_q <= (tail_q == PTR_W'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
      end
      if (pop) begin
        head_q <= (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
      end
      if (push_i && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ tb/sv/tb_dust_low_complexity_read_filter_unit.sv @@
// Testbench of the dust low complexity read filter: directed and random reads are
// streamed in and every class item is checked against a built-in scoring model.
// Depends on dlcrf_pkg, dlcrf_base_if, dlcrf_result_if and the filter unit.
module tb_dust_low_complexity_read_filter_unit;
  import dlcrf_pkg::*;

  localparam int MAX_K        = MAX_K_DEF;
  localparam int MAX_READ_LEN = MAX_READ_LEN_DEF;
  localparam int TABLE_DEPTH  = 1 << (CODE_BITS * MAX_K);
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 560;
  localparam int RANDOM_PHASES = 8;
  localparam int REPORT_LIMIT = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  dlcrf_base_if   in_if ();
  dlcrf_result_if out_if ();

  dust_low_complexity_read_filter_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .out_if     (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  logic [COUNT_W-1:0]         kmer_tally [TABLE_DEPTH];
  logic [EPOCH_W-1:0]         tally_epoch [TABLE_DEPTH];
  logic [EPOCH_W-1:0]         read_number;
  logic [CODE_BITS*MAX_K-1:0] code_window;
  logic [LEN_W-1:0]           bases_seen;
  logic [SCORE_W-1:0]         run_score;
  logic                       too_long;
  logic [MINLEN_W-1:0]        min_len_reg;
  logic [KSZ_W-1:0]           k_reg;
  logic [CUTOFF_W-1:0]        cutoff_reg;

  result_t           expected_classes[$];
  logic [CHAR_W-1:0] first_read[$];
  int unsigned       mismatches = 0;
  int unsigned       cycle_count = 0;
  int unsigned       hold_requests = 0;
  bit                source_gaps_on = 1'b0;
  bit                sink_gaps_on = 1'b0;

  function automatic int unsigned pick_gap(input bit at_least_one);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!at_least_one && r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CODE_BITS-1:0] code_of(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] up;
    up = (ch > FOLD_LIMIT) ? ch - FOLD_OFFSET : ch;
    if (up == CHAR_N) return CODE_N;
    if (up == CHAR_A) return CODE_A;
    if (up == CHAR_C) return CODE_C;
    if (up == CHAR_G) return CODE_G;
    if (up == CHAR_T) return CODE_T;
    return CODE_OTHER;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_nucleotide();
    logic [CHAR_W-1:0] ch;
    case ($urandom_range(0, 4))
      0:       ch = CHAR_N;
      1:       ch = CHAR_A;
      2:       ch = CHAR_C;
      3:       ch = CHAR_G;
      default: ch = CHAR_T;
    endcase
    if ($urandom_range(0, 1) == 1) ch = ch + FOLD_OFFSET;
    return ch;
  endfunction

  function automatic int unsigned active_k();
    if (k_reg < 1) return 1;
    if (k_reg > MAX_K) return MAX_K;
    return k_reg;
  endfunction

  task automatic score_base(input logic [CHAR_W-1:0] ch, input logic last);
    int unsigned k, prior, total, span;
    logic [CODE_BITS*MAX_K-1:0] idx;
    result_t r;
    k = active_k();
    if (bases_seen < MAX_READ_LEN) begin
      code_window = {code_window[CODE_BITS*(MAX_K-1)-1:0], code_of(ch)};
      if (bases_seen >= k - 1) begin
        idx = code_window & (CODE_BITS * MAX_K)'((1 << (CODE_BITS * k)) - 1);
        prior = (tally_epoch[idx] == read_number) ? kmer_tally[idx] : 0;
        total = run_score + prior;
        run_score = (total > SCORE_MAX) ? SCORE_MAX : SCORE_W'(total);
        kmer_tally[idx] = COUNT_W'((prior < COUNT_MAX) ? prior + 1 : prior);
        tally_epoch[idx] = read_number;
      end
      bases_seen++;
    end else begin
      too_long = 1'b1;
    end
    if (last) begin
      span = (bases_seen >= k) ? bases_seen - k + 1 : 0;
      if (min_len_reg != 0 && !too_long && bases_seen < min_len_reg) begin
        r.read_class = CLASS_SHORT;
      end else if (cutoff_reg != 0 && longint'(run_score) > longint'(cutoff_reg) * span) begin
        r.read_class = CLASS_DUST;
      end else begin
        r.read_class = CLASS_PASS;
      end
      r.read_length = bases_seen;
      r.repeat_score = (run_score > SCORE_OUT_MAX) ? SCORE_OUT_MAX : run_score[SCORE_OUT_W-1:0];
      r.length_overflow = too_long;
      expected_classes.insert(expected_classes.size(), r);
      code_window = '0;
      bases_seen = '0;
      run_score = '0;
      too_long = 1'b0;
      read_number++;
      if (read_number == 0) begin
        foreach (tally_epoch[i]) tally_epoch[i] = '0;
        read_number = EPOCH_W'(1);
      end
    end
  endtask

  task automatic send_base(input logic [CHAR_W-1:0] ch, input logic last);
    int unsigned gap;
    gap = source_gaps_on ? pick_gap(1'b0) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.base_char <= ch;
    in_if.last_base <= last;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    score_base(ch, last);
  endtask

  task automatic send_read(input logic [CHAR_W-1:0] chars[$], input bit close);
    foreach (chars[i]) send_base(chars[i], close && (i == chars.size() - 1));
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_classes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_MIN_LENGTH:  min_len_reg = data[MINLEN_W-1:0];
      CFG_KMER_SIZE:   k_reg = data[KSZ_W-1:0];
      CFG_DUST_CUTOFF: cutoff_reg = data[CUTOFF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_filter(input logic [CFG_DATA_W-1:0] min_len, input logic [CFG_DATA_W-1:0] k,
                            input logic [CFG_DATA_W-1:0] cutoff);
    write_reg(CFG_MIN_LENGTH, min_len);
    write_reg(CFG_KMER_SIZE, k);
    write_reg(CFG_DUST_CUTOFF, cutoff);
  endtask

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("mismatch in %s: expected %0d, got %0d, cycle %0d", what, want, got,
               cycle_count);
    end
  endtask

  // The first read runs with the reset configuration and mixes characters that code
  // as zero with both cases of N.
  task automatic test_base_coding();
    logic [CHAR_W-1:0] letters[$];
    first_read = '{8'h00, 8'hFF, 8'h60, 8'hE1, 8'h7F, 8'h80, CHAR_N, CHAR_N + FOLD_OFFSET};
    send_read(first_read, 1'b1);
    wait_drained();
    write_reg(CFG_KMER_SIZE, 16'd1);
    letters = '{CHAR_N, CHAR_N + FOLD_OFFSET, CHAR_A, CHAR_A + FOLD_OFFSET, CHAR_C,
                CHAR_C + FOLD_OFFSET, CHAR_G, CHAR_G + FOLD_OFFSET, CHAR_T,
                CHAR_T + FOLD_OFFSET, CHAR_A + FOLD_OFFSET};
    send_read(letters, 1'b1);
    wait_drained();
  endtask

  task automatic test_class_rules();
    set_filter(16'd5, 16'd4, 16'd1);
    send_read('{CHAR_A, CHAR_C, CHAR_G, CHAR_T}, 1'b1);
    send_read('{CHAR_A, CHAR_A, CHAR_A, CHAR_A, CHAR_A}, 1'b1);
    send_read('{CHAR_A, CHAR_C}, 1'b1);
    wait_drained();
    write_reg(CFG_MIN_LENGTH, 16'd0);
    send_read('{CHAR_A, CHAR_A, CHAR_A}, 1'b1);
    send_read('{CHAR_A, CHAR_A, CHAR_A, CHAR_A, CHAR_A, CHAR_A, CHAR_A}, 1'b1);
    wait_drained();
  endtask

  task automatic test_kmer_size_edges();
    write_reg(CFG_KMER_SIZE, 16'd0);
    send_read('{CHAR_A, CHAR_A, CHAR_A}, 1'b1);
    wait_drained();
    write_reg(CFG_KMER_SIZE, 16'hFFFF);
    send_read('{CHAR_C, CHAR_C, CHAR_C, CHAR_C, CHAR_C, CHAR_C}, 1'b1);
    wait_drained();
    write_reg(CFG_UNUSED, 16'hFFFF);
    send_read('{CHAR_G, CHAR_G}, 1'b1);
    wait_drained();
  endtask

  task automatic test_k_change_mid_read();
    write_reg(CFG_KMER_SIZE, 16'd2);
    send_read('{CHAR_A, CHAR_C, CHAR_A, CHAR_C}, 1'b0);
    wait_drained();
    write_reg(CFG_KMER_SIZE, 16'd3);
    send_read('{CHAR_A, CHAR_C, CHAR_A, CHAR_C, CHAR_A}, 1'b1);
    wait_drained();
  endtask

  task automatic test_overlong_reads();
    logic [CHAR_W-1:0] chars[$];
    set_filter(16'hFFFF, 16'd1, 16'd511);
    repeat (MAX_READ_LEN + 6) chars.insert(chars.size(), CHAR_T + FOLD_OFFSET);
    send_read(chars, 1'b1);
    wait_drained();
  endtask

  task automatic test_output_stall();
    bit saved;
    saved = sink_gaps_on;
    sink_gaps_on = 1'b0;
    source_gaps_on = 1'b0;
    set_filter(16'd0, 16'd1, 16'd0);
    hold_requests++;
    repeat (24) send_base(pick_nucleotide(), 1'b1);
    wait_drained();
    sink_gaps_on = saved;
    source_gaps_on = 1'b1;
  endtask

  task automatic test_random_reads();
    logic [CHAR_W-1:0] chars[$];
    logic [CHAR_W-1:0] motif[4];
    logic [CFG_DATA_W-1:0] min_len, k, cutoff;
    int unsigned sent, len, style, motif_len, r;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 5))
        0:       min_len = '0;
        1:       min_len = CFG_DATA_W'($urandom_range(1, 30));
        2:       min_len = CFG_DATA_W'(MAX_READ_LEN);
        3:       min_len = CFG_DATA_W'($urandom);
        4:       min_len = 16'hFFFF;
        default: min_len = CFG_DATA_W'($urandom_range(1, 10));
      endcase
      k = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
      case ($urandom_range(0, 5))
        0:       cutoff = '0;
        1:       cutoff = 16'hFFFF;
        2:       cutoff = CFG_DATA_W'($urandom);
        3:       cutoff = 16'd1;
        default: cutoff = CFG_DATA_W'($urandom_range(1, 6));
      endcase
      set_filter(min_len, k, cutoff);
      source_gaps_on = (phase % 3 != 0);
      sink_gaps_on = (phase % 4 != 1);
      sent = 0;
      while (sent < RANDOM_ITEMS / RANDOM_PHASES) begin
        r = $urandom_range(0, 99);
        len = (r < 85) ? $urandom_range(1, 24) : (r < 98) ? $urandom_range(25, 100) :
              $urandom_range(101, 400);
        style = $urandom_range(0, 9);
        motif_len = $urandom_range(1, 4);
        foreach (motif[i]) motif[i] = pick_nucleotide();
        chars.delete();
        for (int i = 0; i < len; i++) begin
          if (style < 4) begin
            chars.insert(chars.size(), ($urandom_range(0, 19) == 0) ? pick_nucleotide() :
                                       motif[i % motif_len]);
          end else if (style < 9) begin
            chars.insert(chars.size(), pick_nucleotide());
          end else begin
            chars.insert(chars.size(), CHAR_W'($urandom_range(0, 255)));
          end
        end
        send_read(chars, 1'b1);
        sent += len;
      end
      wait_drained();
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned stall_left;
    int unsigned holds_done;
    stall_left = 0;
    holds_done = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (holds_done != hold_requests) begin
        out_if.ready <= 1'b0;
        stall_left = HOLD_CYCLES - 1;
        holds_done++;
      end else if (sink_gaps_on && $urandom_range(0, 99) < 20) begin
        out_if.ready <= 1'b0;
        stall_left = pick_gap(1'b1) - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_classes.size() == 0) begin
        report_mismatch("item with none expected", 0, out_if.read_class);
      end else begin
        want = expected_classes.pop_front();
        if (out_if.read_class !== want.read_class)
          report_mismatch("read_class", want.read_class, out_if.read_class);
        if (out_if.read_length !== want.read_length)
          report_mismatch("read_length", want.read_length, out_if.read_length);
        if (out_if.repeat_score !== want.repeat_score)
          report_mismatch("repeat_score", want.repeat_score, out_if.repeat_score);
        if (out_if.length_overflow !== want.length_overflow)
          report_mismatch("length_overflow", want.length_overflow, out_if.length_overflow);
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.base_char <= '0;
    in_if.last_base <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_MIN_LENGTH;
    cfg_data_i <= '0;
    foreach (kmer_tally[i]) begin
      kmer_tally[i] = '0;
      tally_epoch[i] = '0;
    end
    read_number = EPOCH_W'(1);
    code_window = '0;
    bases_seen = '0;
    run_score = '0;
    too_long = 1'b0;
    min_len_reg = '0;
    k_reg = KSZ_RESET;
    cutoff_reg = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    source_gaps_on = 1'b1;
    sink_gaps_on = 1'b1;
    test_base_coding();
    test_class_rules();
    test_kmer_size_edges();
    test_k_change_mid_read();
    test_overlong_reads();
    test_output_stall();
    test_random_reads();
    if (mismatches == 0 && expected_classes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
